/* rtl/sbpf_pkg.sv */
package sbpf_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 11;
  localparam int unsigned LEN_W = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned NPAR = 5;

  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned S_TUSER_W = 4;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_TUSER_W = 2;

  localparam logic [7:0] HDR_BYTE        = 8'hFF;
  localparam logic [7:0] INS_PING        = 8'h01;
  localparam logic [7:0] INS_READ        = 8'h02;
  localparam logic [7:0] INS_WRITE       = 8'h03;
  localparam logic [7:0] INS_RESET       = 8'h06;
  localparam logic [7:0] REG_ID          = 8'h03;
  localparam logic [7:0] REG_ANGLE_LIMIT = 8'h06;
  localparam logic [7:0] REG_GOAL        = 8'h1E;
  localparam logic [7:0] REG_SPEED       = 8'h20;
  localparam logic [7:0] REG_PRESENT     = 8'h24;
  localparam logic [7:0] LIMIT_LO        = 8'hFF;
  localparam logic [7:0] LIMIT_HI        = 8'h0F;
  localparam logic [7:0] READ_COUNT      = 8'h02;
  localparam logic [10:0] TURN_LIMIT     = 11'd1023;

  typedef enum logic [3:0] {
    CMD_MOVE      = 4'd0,
    CMD_SPEED     = 4'd1,
    CMD_TURN      = 4'd2,
    CMD_MULTITURN = 4'd3,
    CMD_WHEEL     = 4'd4,
    CMD_JOINT     = 4'd5,
    CMD_RESET     = 4'd6,
    CMD_PING      = 4'd7,
    CMD_SETID     = 4'd8,
    CMD_READPOS   = 4'd9,
    CMD_RXBYTE    = 4'd10
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX       = 2'd0,
    KIND_POS_OK   = 2'd1,
    KIND_POS_FAIL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HDR0  = 3'd1,
    PH_HDR1  = 3'd2,
    PH_ID    = 3'd3,
    PH_LEN   = 3'd4,
    PH_ERR   = 3'd5,
    PH_LOW   = 3'd6,
    PH_HIGH  = 3'd7
  } phase_e;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            id;
    logic [7:0]            instr;
    logic [2:0]            np;
    logic [NPAR-1:0][7:0]  par;
    logic [7:0]            csum;
    logic [15:0]           position;
  } desc_t;

endpackage

/* rtl/servo_bus_packet_framer_top.sv */
// Channel  Dir  Handshake      tdata, low bit up                           tuser  tlast
// s_axis   in   tvalid/tready  servo_id goal_position speed turn_cw new_id rx_byte  cmd  -
// m_axis   out  tvalid/tready  tx_byte position                            kind   last byte
//
// One command word yields 6 to 11 packet words at one word per cycle while
// m_axis_tready is high; the output serializer sets the rate.
// A reply byte yields at most one word.
// A two-entry descriptor queue decouples input from output; s_axis_tready
// drops only while that queue is full or rst is high. Reset (rst, synchronous)
// clears the reply parser and empties the queue and output register.
module servo_bus_packet_framer_top
  import sbpf_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // servo_id[7:0], goal_position[23:8], speed[34:24], turn_cw[35],
  // new_id[43:36], rx_byte[51:44], zero fill
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd[3:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tx_byte[7:0], position[23:8]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [M_TUSER_W-1:0] m_axis_tuser,
  output logic                 m_axis_tlast
);

  logic  q_push, q_pop, q_full, q_empty;
  desc_t q_desc, q_head;

  sbpf_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .q_full   (q_full),
    .in_ready (s_axis_tready),
    .q_push   (q_push),
    .q_desc   (q_desc)
  );

  sbpf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  sbpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

/* rtl/sbpf_front.sv */
module sbpf_front
  import sbpf_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [S_TUSER_W-1:0] in_cmd,
  input  logic [S_TDATA_W-1:0] in_data,
  input  logic                 q_full,
  output logic                 in_ready,
  output logic                 q_push,
  output desc_t                q_desc
);

  phase_e     phase, phase_next;
  logic [7:0] low_byte, low_byte_next;

  logic [7:0]  servo_id, new_id, rx_byte;
  logic [15:0] goal_position;
  logic [10:0] speed, speed_clamped;
  logic        turn_cw;
  logic        accept, emit, is_pkt;
  logic [LEN_W-1:0] pkt_len;
  logic [7:0]  sum;
  desc_t       pkt, rep;
  logic        rep_valid;

  assign servo_id      = in_data[7:0];
  assign goal_position = in_data[23:8];
  assign speed         = in_data[34:24];
  assign turn_cw       = in_data[35];
  assign new_id        = in_data[43:36];
  assign rx_byte       = in_data[51:44];

  assign in_ready = !rst && !q_full;
  assign accept   = in_valid && in_ready;
  assign speed_clamped = (speed > TURN_LIMIT) ? TURN_LIMIT : speed;
  assign pkt_len  = LEN_W'(pkt.np) + LEN_W'(6);

  always_comb begin
    pkt = '0;
    pkt.kind = KIND_TX;
    pkt.id   = servo_id;
    is_pkt   = 1'b1;
    unique case (in_cmd)
      CMD_MOVE: begin
        pkt.instr = INS_WRITE;
        pkt.np    = 3'd3;
        pkt.par[0] = REG_GOAL;
        pkt.par[1] = goal_position[7:0];
        pkt.par[2] = goal_position[15:8];
      end
      CMD_SPEED: begin
        pkt.instr = INS_WRITE;
        pkt.np    = 3'd3;
        pkt.par[0] = REG_SPEED;
        pkt.par[1] = speed[7:0];
        pkt.par[2] = {5'd0, speed[10:8]};
      end
      CMD_TURN: begin
        pkt.instr = INS_WRITE;
        pkt.np    = 3'd3;
        pkt.par[0] = REG_SPEED;
        pkt.par[1] = speed_clamped[7:0];
        pkt.par[2] = {5'd0, turn_cw, speed_clamped[9:8]};
      end
      CMD_MULTITURN: begin
        pkt.instr = INS_WRITE;
        pkt.np    = 3'd5;
        pkt.par[0] = REG_ANGLE_LIMIT;
        pkt.par[1] = LIMIT_LO;
        pkt.par[2] = LIMIT_HI;
        pkt.par[3] = LIMIT_LO;
        pkt.par[4] = LIMIT_HI;
      end
      CMD_WHEEL: begin
        pkt.instr = INS_WRITE;
        pkt.np    = 3'd5;
        pkt.par[0] = REG_ANGLE_LIMIT;
      end
      CMD_JOINT: begin
        pkt.instr = INS_WRITE;
        pkt.np    = 3'd5;
        pkt.par[0] = REG_ANGLE_LIMIT;
        pkt.par[3] = LIMIT_LO;
        pkt.par[4] = LIMIT_HI;
      end
      CMD_RESET: begin
        pkt.instr = INS_RESET;
      end
      CMD_PING: begin
        pkt.instr = INS_PING;
      end
      CMD_SETID: begin
        pkt.instr = INS_WRITE;
        pkt.np    = 3'd2;
        pkt.par[0] = REG_ID;
        pkt.par[1] = new_id;
      end
      CMD_READPOS: begin
        pkt.instr = INS_READ;
        pkt.np    = 3'd2;
        pkt.par[0] = REG_PRESENT;
        pkt.par[1] = READ_COUNT;
      end
      default: begin
        is_pkt = 1'b0;
      end
    endcase
    sum = pkt.id + {5'd0, pkt.np} + 8'd2 + pkt.instr
        + pkt.par[0] + pkt.par[1] + pkt.par[2] + pkt.par[3] + pkt.par[4];
    pkt.csum = ~sum;
  end

  always_comb begin
    phase_next    = phase;
    low_byte_next = low_byte;
    rep           = '0;
    rep_valid     = 1'b0;
    emit          = 1'b0;
    if (in_cmd == CMD_RXBYTE) begin
      unique case (phase)
        PH_IDLE: ;
        PH_HDR0: begin
          if (rx_byte != HDR_BYTE) begin
            rep_valid  = 1'b1;
            rep.kind   = KIND_POS_FAIL;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_HDR1;
          end
        end
        PH_HDR1: phase_next = PH_ID;
        PH_ID:   phase_next = PH_LEN;
        PH_LEN:  phase_next = PH_ERR;
        PH_ERR: begin
          if (rx_byte != 8'd0) begin
            rep_valid  = 1'b1;
            rep.kind   = KIND_POS_FAIL;
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_LOW;
          end
        end
        PH_LOW: begin
          low_byte_next = rx_byte;
          phase_next    = PH_HIGH;
        end
        PH_HIGH: begin
          rep_valid    = 1'b1;
          rep.kind     = KIND_POS_OK;
          rep.position = {rx_byte, low_byte};
          phase_next   = PH_IDLE;
        end
        default: phase_next = PH_IDLE;
      endcase
    end else if (is_pkt) begin
      phase_next = PH_IDLE;
      if (pkt_len <= LEN_W'(MAX_PACKET_BYTES)) begin
        emit = 1'b1;
        if (in_cmd == CMD_READPOS) begin
          phase_next = PH_HDR0;
        end
      end
    end
  end

  assign q_push = accept && (rep_valid || emit);
  assign q_desc = rep_valid ? rep : pkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      low_byte <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      low_byte <= low_byte_next;
    end
  end

endmodule

/* rtl/sbpf_fifo.sv */
module sbpf_fifo
  import sbpf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output desc_t head
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/sbpf_back.sv */
module sbpf_back
  import sbpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  desc_t                q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [M_TDATA_W-1:0] out_data,
  output logic [M_TUSER_W-1:0] out_kind,
  output logic                 out_last
);

  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] last_idx;
  logic             load, done;
  logic [7:0]       byte_sel;
  logic [7:0]       tx_byte;
  logic [15:0]      position;
  kind_e            kind;

  assign last_idx = LEN_W'(q_head.np) + LEN_W'(5);
  assign load     = !q_empty && (!out_valid || out_ready);
  assign done     = (q_head.kind != KIND_TX) || (idx == last_idx);
  assign q_pop    = load && done;

  always_comb begin
    if (idx == last_idx) begin
      byte_sel = q_head.csum;
    end else begin
      case (idx)
        4'd0, 4'd1: byte_sel = HDR_BYTE;
        4'd2:       byte_sel = q_head.id;
        4'd3:       byte_sel = {5'd0, q_head.np} + 8'd2;
        4'd4:       byte_sel = q_head.instr;
        4'd5:       byte_sel = q_head.par[0];
        4'd6:       byte_sel = q_head.par[1];
        4'd7:       byte_sel = q_head.par[2];
        4'd8:       byte_sel = q_head.par[3];
        4'd9:       byte_sel = q_head.par[4];
        default:    byte_sel = q_head.csum;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= done ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind <= q_head.kind;
      if (q_head.kind == KIND_TX) begin
        tx_byte  <= byte_sel;
        out_last <= (idx == last_idx);
        position <= '0;
      end else begin
        tx_byte  <= '0;
        out_last <= 1'b0;
        position <= q_head.position;
      end
    end
  end

  assign out_data = {position, tx_byte};
  assign out_kind = kind;

endmodule
